>>> sv/rbd_pkg.sv
// rbd_pkg: shared types and constants for the RGB box downsampler.
// Holds the beat structs, register indexes and lane geometry.
// No dependencies.
`default_nettype none
package rbd_pkg;

  // Default column capacity of the source image.
  localparam int MaxSrcWidthDef = 2048;
  // The row counter is fixed: the height register never enables past this.
  localparam int MaxSrcHeight = 2048;
  localparam int RowW = $clog2(MaxSrcHeight);

  localparam int CfgW = 12;
  localparam int CfgIdxW = 2;
  localparam int ChanW = 8;
  localparam int LaneW = 12;
  localparam int SumW = 3 * LaneW;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_BLOCK_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT = 2'd2;

  // Block modes.
  localparam logic [1:0] MODE_2X2 = 2'd1;
  localparam logic [1:0] MODE_4X4 = 2'd2;

  localparam logic [1:0] RESET_MODE = MODE_2X2;
  localparam logic [CfgW-1:0] RESET_WIDTH = 12'd640;
  localparam logic [CfgW-1:0] RESET_HEIGHT = 12'd480;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } in_pix_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             row_end;
    logic             frame_end;
  } out_pix_t;

endpackage
`default_nettype wire

>>> sv/rgb_box_downsample.sv
// rgb_box_downsample: top level of the 2x2 / 4x4 RGB box downsampler.
// Depends on rbd_pkg, rbd_colmem and rbd_outq.
`default_nettype none
// Source pixels enter in raster order and one averaged pixel leaves per completed
// block: the floor of the per-channel mean over 2x2 blocks (block_mode 1) or 4x4
// blocks (block_mode 2). The block takes one pixel per clock while in_stall is low.
// In the first pipeline stage the horizontal partial sum is formed and the
// column-sum memory is read, in the second the column sum is added and either
// written back (upper rows of a block) or turned into a result. Results pass
// through a two-entry queue; input is held off only while that queue, counting a
// result still in flight, is full, so a result waiting at the output does not stop
// the input. A result is registered in the second-stage registers and then in the
// queue before it reaches the output. The column-sum memory needs no clearing pass
// after reset: every entry is written on the first row of its block before it is
// read. Any write to a defined register restarts the frame at the top left. With
// an unsupported mode, a zero or oversized dimension, or a dimension that is not a
// multiple of the block size, pixels are still accepted but ignored.
module rgb_box_downsample #(
  parameter int MAX_SRC_WIDTH = rbd_pkg::MaxSrcWidthDef
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rbd_pkg::in_pix_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rbd_pkg::out_pix_t                out_data,
  input  wire logic                        cfg_write,
  input  wire logic [rbd_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [rbd_pkg::CfgW-1:0]    cfg_data
);
  import rbd_pkg::*;

  localparam int ColW = $clog2(MAX_SRC_WIDTH);
  localparam int Depth = MAX_SRC_WIDTH / 2;
  localparam int AddrW = ColW - 1;
  // Common width for comparing the column counter against the width register.
  localparam int CmpW = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;

  // Configuration registers.
  logic [1:0]      block_mode;
  logic [CfgW-1:0] src_width;
  logic [CfgW-1:0] src_height;
  logic            cfg_hit;

  assign cfg_hit = cfg_write && (cfg_index == REG_BLOCK_MODE
                                 || cfg_index == REG_SRC_WIDTH
                                 || cfg_index == REG_SRC_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_mode <= RESET_MODE;
      src_width <= RESET_WIDTH;
      src_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLOCK_MODE: block_mode <= cfg_data[1:0];
        REG_SRC_WIDTH:  src_width <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        default:        block_mode <= block_mode;
      endcase
    end
  end

  // Decode of the geometry. The block mask is 01 for 2x2 and 11 for 4x4.
  logic       mode_ok;
  logic       wide;
  logic [1:0] bmask;
  logic       width_ok;
  logic       height_ok;
  logic       enabled;

  assign mode_ok = (block_mode == MODE_2X2) || (block_mode == MODE_4X4);
  assign wide = (block_mode == MODE_4X4);
  assign bmask = wide ? 2'b11 : 2'b01;
  assign width_ok = (src_width != '0)
                    && (CmpW'(src_width) <= CmpW'(MAX_SRC_WIDTH))
                    && ((src_width[1:0] & bmask) == 2'b00);
  assign height_ok = (src_height != '0)
                     && (src_height <= CfgW'(MaxSrcHeight))
                     && ((src_height[1:0] & bmask) == 2'b00);
  assign enabled = mode_ok && width_ok && height_ok;

  // Handshake. Space is reserved for a result still in the second stage.
  logic [1:0] q_count;
  logic       s1_valid;
  logic       s1_emit;
  logic [1:0] pending;
  logic       accept;
  logic       work;

  assign pending = q_count + {1'b0, s1_valid && s1_emit};
  assign in_stall = (pending >= 2'd2);
  assign accept = in_valid && !in_stall;
  assign work = accept && enabled;

  // First stage: raster position, horizontal partial sum, memory read.
  logic [ColW-1:0] source_column;
  logic [RowW-1:0] source_row;
  logic [SumW-1:0] horizontal_partial;
  logic [SumW-1:0] pix;
  logic [SumW-1:0] hsum;
  logic            col_last;
  logic            row_first;
  logic            row_last;
  logic            line_end;
  logic            frame_last;
  logic [AddrW-1:0] outcol;
  logic            rd_en;
  logic [SumW-1:0] rd_data;

  assign pix = {4'b0, in_data.in_blue, 4'b0, in_data.in_green, 4'b0, in_data.in_red};
  assign hsum = ((source_column[1:0] & bmask) == 2'b00) ? pix : horizontal_partial + pix;
  assign col_last = ((source_column[1:0] & bmask) == bmask);
  assign row_first = ((source_row[1:0] & bmask) == 2'b00);
  assign row_last = ((source_row[1:0] & bmask) == bmask);
  assign line_end = ((CmpW'(source_column) + CmpW'(1)) >= CmpW'(src_width));
  assign frame_last = ((CfgW'(source_row) + CfgW'(1)) >= src_height);
  assign outcol = wide ? AddrW'(source_column >> 2) : AddrW'(source_column >> 1);
  assign rd_en = work && col_last && !row_first;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      source_column <= '0;
      source_row <= '0;
      horizontal_partial <= '0;
    end else if (work) begin
      horizontal_partial <= col_last ? '0 : hsum;
      if (line_end) begin
        source_column <= '0;
        source_row <= frame_last ? '0 : source_row + RowW'(1);
      end else begin
        source_column <= source_column + ColW'(1);
      end
    end
  end

  // Second-stage registers.
  logic             s1_write;
  logic             s1_use_mem;
  logic             s1_wide;
  logic             s1_rend;
  logic             s1_fend;
  logic [AddrW-1:0] s1_addr;
  logic [SumW-1:0]  s1_hsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit <= 1'b0;
      s1_write <= 1'b0;
    end else begin
      s1_valid <= work && col_last;
      s1_emit <= work && col_last && row_last;
      s1_write <= work && col_last && !row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      s1_use_mem <= !row_first;
      s1_wide <= wide;
      s1_rend <= line_end;
      s1_fend <= line_end && frame_last;
      s1_addr <= outcol;
      s1_hsum <= hsum;
    end
  end

  // Second stage: add the column sum, then write back or emit.
  logic [SumW-1:0] s1_total;
  logic            wr_en;
  logic            push;
  out_pix_t        push_data;

  assign s1_total = s1_use_mem ? rd_data + s1_hsum : s1_hsum;
  assign wr_en = s1_valid && s1_write;
  assign push = s1_valid && s1_emit;

  always_comb begin
    push_data.out_red = s1_wide ? s1_total[11:4] : s1_total[9:2];
    push_data.out_green = s1_wide ? s1_total[23:16] : s1_total[21:14];
    push_data.out_blue = s1_wide ? s1_total[35:28] : s1_total[33:26];
    push_data.row_end = s1_rend;
    push_data.frame_end = s1_fend;
  end

  rbd_colmem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_colmem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (outcol),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (s1_total)
  );

  rbd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_count)
  );

  // A read in the same cycle as a write to the same column would return stale
  // data; the raster order keeps the two at least one image row apart.
  assert property (@(posedge clk) disable iff (rst)
                   (rd_en && wr_en) |-> (outcol != s1_addr))
    else $error("rgb_box_downsample: column read collides with write-back");

  // The second stage either writes a column sum back or emits, never both.
  assert property (@(posedge clk) disable iff (rst)
                   s1_valid |-> (s1_emit != s1_write))
    else $error("rgb_box_downsample: second stage action is ambiguous");

  // A register write puts the raster position back to the top left.
  assert property (@(posedge clk) disable iff (rst)
                   cfg_hit |=> (source_column == '0 && source_row == '0))
    else $error("rgb_box_downsample: frame did not restart after register write");

endmodule
`default_nettype wire

>>> sv/rbd_colmem.sv
// rbd_colmem: column-sum memory, one write port and one registered read port.
// Uses rbd_pkg for the sum width.
`default_nettype none
module rbd_colmem #(
  parameter int Depth = 1024,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AddrW-1:0]         rd_addr,
  output logic      [rbd_pkg::SumW-1:0] rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AddrW-1:0]         wr_addr,
  input  wire logic [rbd_pkg::SumW-1:0] wr_data
);
  import rbd_pkg::*;

  logic [SumW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> sv/rbd_outq.sv
// rbd_outq: two-entry result queue that decouples the pipeline from out_stall.
// Uses rbd_pkg for the output beat type.
`default_nettype none
module rbd_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire rbd_pkg::out_pix_t push_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rbd_pkg::out_pix_t      out_data,
  output logic [1:0]             count
);
  import rbd_pkg::*;

  out_pix_t q [2];
  logic     wr_ptr;
  logic     rd_ptr;
  logic     pop;

  assign out_valid = (count != 2'd0);
  assign out_data = q[rd_ptr];
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // The upstream credit check must never let a push land on a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> (count != 2'd2))
    else $error("rbd_outq: push into full queue");

endmodule
`default_nettype wire
